FILE: rtl/core/tsw_pkg.sv
// Shared types and constants for the tilt-to-steering-wheel block.
// Holds the CORDIC arctangent table, angle constants and register indexes.
// No dependencies.
package tsw_pkg;

    localparam int MaxSteps = 24;

    // CORDIC datapath widths
    localparam int CW = 27;   // X and Y: |in|*256 with CORDIC gain stays below 2^25
    localparam int AW = 25;   // signed angle accumulator, degrees in Q16

    localparam logic [22:0] ANG_45 = 23'd2949120;
    localparam logic [22:0] ANG_90 = 23'd5898240;

    // q / 45 as (q * RECIP_45) >> RECIP_SHIFT, low by at most one
    localparam logic [15:0] RECIP_45    = 16'd46603;
    localparam int          RECIP_SHIFT = 21;
    localparam logic [5:0]  DIV_45      = 6'd45;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam logic [22:0] ATAN_DEG_Q16 [MaxSteps] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef enum logic [1:0] {
        REG_COARSE_DZ = 2'd0,
        REG_FINE_DZ   = 2'd1,
        REG_RANGE     = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic zero;   // coarse deadzone or x == 0
        logic inv;    // unit held inverted (z > 0)
        logic neg;    // x > 0, output negative
    } t_flags;

endpackage

FILE: rtl/core/tilt_to_steering_wheel.sv
// Tilt-to-steering-wheel top level: APB register file, unrolled CORDIC
// vectoring pipeline and scaling stages. Depends on tsw_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one accelerometer item:
//   i_accel_x and i_accel_z, 16-bit two's complement. Output channel
//   (o_valid / i_ready) returns one 11-bit signed o_wheel_value per item.
//   An accepted item passes through the capture stage (loaded at the
//   accepting edge), one stage per CORDIC iteration and four scaling
//   stages to o_valid. Throughput is one item per cycle while the receiver
//   does not stall: every CORDIC iteration has its own adder stage, so
//   nothing is shared between items.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; while the receiver stalls with a result held,
//   o_ready is low and every stage holds its item.
//   Registers are written through the APB port at 0x0 (coarse deadzone),
//   0x4 (fine deadzone) and 0x8 (wheel range); write them only while the
//   pipeline is empty. Reset empties the pipeline and loads the register
//   defaults 6, 3 and 255.
module tilt_to_steering_wheel #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [10:0] o_wheel_value,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tsw_pkg::*;

    localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [9:0] r_coarse, r_fine, r_range;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse <= 10'd6;
            r_fine   <= 10'd3;
            r_range  <= 10'd255;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_COARSE_DZ: r_coarse <= pwdata[9:0];
                REG_FINE_DZ:   r_fine   <= pwdata[9:0];
                REG_RANGE:     r_range  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COARSE_DZ: prdata = {22'd0, r_coarse};
            REG_FINE_DZ:   prdata = {22'd0, r_fine};
            REG_RANGE:     prdata = {22'd0, r_range};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together
    // ------------------------------------------------------------------
    logic r_o_vld;
    logic en;

    assign en      = !r_o_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_o_vld;

    // ------------------------------------------------------------------
    // Capture stage: magnitudes and special-case flags
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_cx [Steps+1];
    logic signed [CW-1:0] r_cy [Steps+1];
    logic signed [AW-1:0] r_ca [Steps+1];
    t_flags               r_cf [Steps+1];
    logic                 r_cv [Steps+1];

    logic [16:0] abs_x, abs_z;
    t_flags      n_f0;

    always_comb begin
        abs_x     = i_accel_x[15] ? 17'(-$signed({i_accel_x[15], i_accel_x}))
                                  : {1'b0, i_accel_x};
        abs_z     = i_accel_z[15] ? 17'(-$signed({i_accel_z[15], i_accel_z}))
                                  : {1'b0, i_accel_z};
        n_f0.zero = (abs_x < 17'(r_coarse)) || (i_accel_x == 16'sd0);
        n_f0.inv  = !i_accel_z[15] && (i_accel_z != 16'sd0);
        n_f0.neg  = !i_accel_x[15] && (i_accel_x != 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= $signed({2'b00, abs_x, 8'h00});
            r_cy[0] <= $signed({2'b00, abs_z, 8'h00});
            r_ca[0] <= '0;
            r_cf[0] <= n_f0;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring, one iteration per stage
    // ------------------------------------------------------------------
    for (genvar i = 0; i < Steps; i++) begin : g_cordic
        logic signed [CW-1:0] xs, ys;
        logic signed [CW-1:0] n_x, n_y;
        logic signed [AW-1:0] n_a;
        logic signed [AW-1:0] step_ang;

        always_comb begin
            xs       = r_cx[i] >>> i;
            ys       = r_cy[i] >>> i;
            step_ang = $signed({2'b00, ATAN_DEG_Q16[i]});
            if (!r_cy[i][CW-1]) begin
                n_x = r_cx[i] + ys;
                n_y = r_cy[i] - xs;
                n_a = r_ca[i] + step_ang;
            end else begin
                n_x = r_cx[i] - ys;
                n_y = r_cy[i] + xs;
                n_a = r_ca[i] - step_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[i+1] <= n_x;
                r_cy[i+1] <= n_y;
                r_ca[i+1] <= n_a;
                r_cf[i+1] <= r_cf[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale 1: clamp angle, d = 90 - theta
    // ------------------------------------------------------------------
    logic signed [AW-1:0] ang;
    logic [22:0]          ang_clamped;
    logic [22:0]          n_d;
    logic                 r_v1, r_ge1;
    logic [21:0]          r_d1;
    t_flags               r_f1;

    always_comb begin
        ang = r_ca[Steps];
        if (ang[AW-1]) begin
            ang_clamped = '0;
        end else if (ang > $signed({2'b00, ANG_90})) begin
            ang_clamped = ANG_90;
        end else begin
            ang_clamped = ang[22:0];
        end
        n_d = ANG_90 - ang_clamped;
    end

    // ------------------------------------------------------------------
    // Scale 2: range * d
    // ------------------------------------------------------------------
    logic        r_v2, r_ge2;
    logic [31:0] r_p2;
    t_flags      r_f2;

    // ------------------------------------------------------------------
    // Scale 3: estimate (range * d >> 16) / 45 by reciprocal
    // ------------------------------------------------------------------
    logic        r_v3, r_ge3;
    logic [15:0] r_q3;
    logic [10:0] r_m3;
    logic [31:0] recip_prod;
    t_flags      r_f3;

    assign recip_prod = r_p2[31:16] * RECIP_45;

    // ------------------------------------------------------------------
    // Output stage: correct quotient, select magnitude, apply deadzones and sign
    // ------------------------------------------------------------------
    logic [15:0]        rem;
    logic [9:0]         quot;
    logic [9:0]         mag;
    logic signed [10:0] n_wheel;
    logic signed [10:0] r_wheel;

    always_comb begin
        rem  = r_q3 - 16'(r_m3) * 16'(DIV_45);
        quot = 10'(r_m3 + 11'(rem >= 16'(DIV_45)));
        mag  = r_ge3 ? r_range : quot;
        if (mag < r_fine) begin
            mag = '0;
        end
        if (r_f3.zero) begin
            mag = '0;
        end else if (r_f3.inv) begin
            mag = r_range;   // inverted unit skips the fine deadzone
        end
        n_wheel = r_f3.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_v1    <= r_cv[Steps];
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_o_vld <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1    <= n_d[21:0];
            r_ge1   <= (n_d >= ANG_45);
            r_f1    <= r_cf[Steps];

            r_p2    <= r_range * r_d1;
            r_ge2   <= r_ge1;
            r_f2    <= r_f1;

            r_q3    <= r_p2[31:16];
            r_m3    <= recip_prod[31:RECIP_SHIFT];
            r_ge3   <= r_ge2;
            r_f3    <= r_f2;

            r_wheel <= n_wheel;
        end
    end

    assign o_wheel_value = r_wheel;

endmodule
